// ----- rtl/core/nsd_pkg.sv -----
`timescale 1ns / 1ps

package nsd_pkg;

    // Default coordinate width (width/height saturate at 2^bits - 1)
    localparam int NSD_COORD_BITS = 16;

    // Command queue between parser and emitter
    localparam int NSD_QDEPTH = 4;
    localparam int NSD_QPTR_BITS = $clog2(NSD_QDEPTH);

    // Result kinds
    localparam logic [1:0] KIND_HEADER   = 2'd0;
    localparam logic [1:0] KIND_PIXEL    = 2'd1;
    localparam logic [1:0] KIND_ERROR    = 2'd2;
    localparam logic [1:0] KIND_COMPLETE = 2'd3;

    // Error codes
    localparam logic [2:0] ERR_NONE      = 3'd0;
    localparam logic [2:0] ERR_MAGIC     = 3'd1;
    localparam logic [2:0] ERR_SEP       = 3'd2;
    localparam logic [2:0] ERR_MAXVAL    = 3'd3;
    localparam logic [2:0] ERR_TRUNC     = 3'd4;

    // File formats
    localparam logic [2:0] FMT_UNKNOWN   = 3'd0;
    localparam logic [2:0] FMT_PBM_ASCII = 3'd1;
    localparam logic [2:0] FMT_PGM_ASCII = 3'd2;
    localparam logic [2:0] FMT_PPM_ASCII = 3'd3;
    localparam logic [2:0] FMT_PBM_RAW   = 3'd4;
    localparam logic [2:0] FMT_PGM_RAW   = 3'd5;
    localparam logic [2:0] FMT_PPM_RAW   = 3'd6;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_ONE   = 8'h31;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [15:0] SAMPLE_MAX8  = 16'd255;
    localparam logic [15:0] SAMPLE_MAX16 = 16'd65535;
    localparam logic [16:0] ACC_SAT      = 17'd65536;

    // Primary item of one command
    typedef enum logic [2:0] {
        PR_NONE,
        PR_HEADER,
        PR_PIXEL,
        PR_ERROR,
        PR_BITS
    } prim_t;

    // Item that follows the primary one
    typedef enum logic [1:0] {
        TR_NONE,
        TR_COMPLETE,
        TR_TRUNC
    } trail_t;

    // One parsed byte's worth of output work
    typedef struct packed {
        prim_t       prim;
        trail_t      trail;
        logic [2:0]  fmt;
        logic [2:0]  err;
        logic [15:0] val_a;   // width or red
        logic [15:0] val_b;   // height or green
        logic [15:0] val_c;   // maxval or blue
        logic [15:0] col;
        logic [15:0] row;
        logic [7:0]  bits;    // raw bitmap byte
        logic [3:0]  cnt;     // bitmap pixels in this byte, 1..8
    } cmd_t;

endpackage

// ----- rtl/core/nsd_front.sv -----
`timescale 1ns / 1ps

module nsd_front #(
    parameter int COORD_BITS = nsd_pkg::NSD_COORD_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_fire,
    input  logic [7:0]       data_byte,
    input  logic             end_of_file,
    output logic             push,
    output nsd_pkg::cmd_t    cmd
);

    typedef enum logic [3:0] {
        PH_MAGIC0,
        PH_MAGIC1,
        PH_SEP,
        PH_WIDTH,
        PH_HEIGHT,
        PH_MAXV,
        PH_RASTER,
        PH_DONE,
        PH_ERR
    } phase_t;

    localparam logic [16:0] COORD_MAX = 17'((1 << COORD_BITS) - 1);

    phase_t                phase_reg, phase_next;
    logic [2:0]            fmt_reg, fmt_next;
    logic [COORD_BITS-1:0] width_reg, width_next;
    logic [COORD_BITS-1:0] height_reg, height_next;
    logic [15:0]           maxval_reg, maxval_next;
    logic [16:0]           acc_reg, acc_next;
    logic                  tok_reg, tok_next;
    logic                  cmt_reg, cmt_next;
    logic [COORD_BITS-1:0] col_reg, col_next;
    logic [COORD_BITS-1:0] row_reg, row_next;
    logic [1:0]            ch_reg, ch_next;
    logic [7:0]            hb_reg, hb_next;
    logic                  half_reg, half_next;
    logic [15:0]           red_hold_reg, red_hold_next;
    logic [15:0]           green_hold_reg, green_hold_next;

    logic                  is_digit, is_space, is_hash;
    logic [20:0]           acc_prod;
    logic                  tok_end;
    logic [16:0]           tok_val;
    logic                  hdr_ev;
    logic                  smp_ev;
    logic [15:0]           smp_val;
    logic                  pix_ev;
    logic [15:0]           pix_r, pix_g, pix_b;
    logic                  p4_ev;
    logic [COORD_BITS:0]   col_inc, row_inc, col_sum;
    logic [COORD_BITS-1:0] p4_rem;
    logic [3:0]            p4_cnt;
    logic [15:0]           smp_lim;

    // Byte classes
    assign is_digit = (data_byte >= nsd_pkg::CH_ZERO) && (data_byte <= nsd_pkg::CH_NINE);
    assign is_space = (data_byte == nsd_pkg::CH_SPACE)
                   || ((data_byte >= nsd_pkg::CH_TAB) && (data_byte <= nsd_pkg::CH_CR));
    assign is_hash  = (data_byte == nsd_pkg::CH_HASH);

    // Decimal accumulate, saturating
    assign acc_prod = {1'b0, acc_reg, 3'b000} + {3'b000, acc_reg, 1'b0}
                    + 21'(data_byte - nsd_pkg::CH_ZERO);

    // Parser: one byte per cycle, taken only when in_fire is high
    always_comb
    begin
        phase_next      = phase_reg;
        fmt_next        = fmt_reg;
        width_next      = width_reg;
        height_next     = height_reg;
        maxval_next     = maxval_reg;
        acc_next        = acc_reg;
        tok_next        = tok_reg;
        cmt_next        = cmt_reg;
        col_next        = col_reg;
        row_next        = row_reg;
        ch_next         = ch_reg;
        hb_next         = hb_reg;
        half_next       = half_reg;
        red_hold_next   = red_hold_reg;
        green_hold_next = green_hold_reg;

        cmd       = '0;
        cmd.prim  = nsd_pkg::PR_NONE;
        cmd.trail = nsd_pkg::TR_NONE;
        tok_end   = 1'b0;
        tok_val   = '0;
        hdr_ev    = 1'b0;
        smp_ev    = 1'b0;
        smp_val   = '0;
        pix_ev    = 1'b0;
        pix_r     = '0;
        pix_g     = '0;
        pix_b     = '0;
        p4_ev     = 1'b0;
        col_inc   = '0;
        row_inc   = '0;
        col_sum   = '0;
        p4_rem    = '0;
        p4_cnt    = '0;
        smp_lim   = '0;

        case (phase_reg)
            PH_MAGIC0:
            begin
                if (data_byte == nsd_pkg::CH_P)
                begin
                    phase_next = PH_MAGIC1;
                end
                else
                begin
                    cmd.prim   = nsd_pkg::PR_ERROR;
                    cmd.err    = nsd_pkg::ERR_MAGIC;
                    phase_next = PH_ERR;
                end
            end
            PH_MAGIC1:
            begin
                if ((data_byte >= nsd_pkg::CH_ONE) && (data_byte <= nsd_pkg::CH_SIX))
                begin
                    fmt_next   = data_byte[2:0];
                    phase_next = PH_SEP;
                end
                else
                begin
                    cmd.prim   = nsd_pkg::PR_ERROR;
                    cmd.err    = nsd_pkg::ERR_MAGIC;
                    phase_next = PH_ERR;
                end
            end
            PH_SEP:
            begin
                if (is_space)
                begin
                    phase_next = PH_WIDTH;
                end
                else
                begin
                    cmd.prim   = nsd_pkg::PR_ERROR;
                    cmd.err    = nsd_pkg::ERR_SEP;
                    phase_next = PH_ERR;
                end
            end
            PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_RASTER:
            begin
                if (cmt_reg)
                begin
                    if ((data_byte == nsd_pkg::CH_LF) || (data_byte == nsd_pkg::CH_CR))
                    begin
                        cmt_next = 1'b0;
                    end
                end
                else if ((phase_reg == PH_RASTER) && (fmt_reg == nsd_pkg::FMT_PBM_ASCII))
                begin
                    if (data_byte == nsd_pkg::CH_ONE)
                    begin
                        pix_ev = 1'b1;
                    end
                    else if (data_byte == nsd_pkg::CH_ZERO)
                    begin
                        pix_ev = 1'b1;
                        pix_r  = nsd_pkg::SAMPLE_MAX8;
                        pix_g  = nsd_pkg::SAMPLE_MAX8;
                        pix_b  = nsd_pkg::SAMPLE_MAX8;
                    end
                    else if (is_hash)
                    begin
                        cmt_next = 1'b1;
                    end
                end
                else if ((phase_reg == PH_RASTER) && (fmt_reg == nsd_pkg::FMT_PBM_RAW))
                begin
                    p4_ev = 1'b1;
                end
                else if ((phase_reg == PH_RASTER) && ((fmt_reg == nsd_pkg::FMT_PGM_RAW)
                         || (fmt_reg == nsd_pkg::FMT_PPM_RAW)))
                begin
                    if (maxval_reg > nsd_pkg::SAMPLE_MAX8)
                    begin
                        if (!half_reg)
                        begin
                            hb_next   = data_byte;
                            half_next = 1'b1;
                        end
                        else
                        begin
                            half_next = 1'b0;
                            smp_ev    = 1'b1;
                            smp_val   = {hb_reg, data_byte};
                        end
                    end
                    else
                    begin
                        smp_ev  = 1'b1;
                        smp_val = {8'h00, data_byte};
                    end
                end
                else
                begin
                    // Decimal text: header numbers and ASCII samples
                    if (is_digit)
                    begin
                        acc_next = (acc_prod > {4'b0000, nsd_pkg::ACC_SAT})
                                 ? nsd_pkg::ACC_SAT : acc_prod[16:0];
                        tok_next = 1'b1;
                    end
                    else if (is_hash)
                    begin
                        if (tok_reg)
                        begin
                            tok_end  = 1'b1;
                            tok_next = 1'b0;
                        end
                        cmt_next = 1'b1;
                    end
                    else if (is_space)
                    begin
                        if (tok_reg)
                        begin
                            tok_end  = 1'b1;
                            tok_next = 1'b0;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase

        // End of file closes a pending number
        if (end_of_file && tok_next && (phase_next == PH_WIDTH || phase_next == PH_HEIGHT
            || phase_next == PH_MAXV || phase_next == PH_RASTER))
        begin
            tok_end  = 1'b1;
            tok_next = 1'b0;
        end

        // Number finished
        if (tok_end)
        begin
            tok_val  = acc_next;
            acc_next = '0;
            smp_lim  = (maxval_reg > nsd_pkg::SAMPLE_MAX8)
                     ? nsd_pkg::SAMPLE_MAX16 : nsd_pkg::SAMPLE_MAX8;
            case (phase_next)
                PH_WIDTH:
                begin
                    width_next = (tok_val > COORD_MAX) ? COORD_BITS'(COORD_MAX)
                                                       : COORD_BITS'(tok_val);
                    phase_next = PH_HEIGHT;
                end
                PH_HEIGHT:
                begin
                    height_next = (tok_val > COORD_MAX) ? COORD_BITS'(COORD_MAX)
                                                        : COORD_BITS'(tok_val);
                    if ((fmt_reg == nsd_pkg::FMT_PBM_ASCII) || (fmt_reg == nsd_pkg::FMT_PBM_RAW))
                    begin
                        maxval_next = 16'd1;
                        hdr_ev      = 1'b1;
                    end
                    else
                    begin
                        phase_next = PH_MAXV;
                    end
                end
                PH_MAXV:
                begin
                    if (tok_val[16])
                    begin
                        cmd.prim   = nsd_pkg::PR_ERROR;
                        cmd.err    = nsd_pkg::ERR_MAXVAL;
                        phase_next = PH_ERR;
                    end
                    else
                    begin
                        maxval_next = tok_val[15:0];
                        hdr_ev      = 1'b1;
                    end
                end
                PH_RASTER:
                begin
                    smp_ev  = 1'b1;
                    smp_val = ({1'b0, smp_lim} < tok_val) ? smp_lim : tok_val[15:0];
                end
                default:
                begin
                end
            endcase
        end

        // Header item
        if (hdr_ev)
        begin
            cmd.prim  = nsd_pkg::PR_HEADER;
            cmd.val_a = 16'(width_next);
            cmd.val_b = 16'(height_next);
            cmd.val_c = maxval_next;
            col_next  = '0;
            row_next  = '0;
            ch_next   = '0;
            half_next = 1'b0;
            if ((width_next == '0) || (height_next == '0))
            begin
                cmd.trail  = nsd_pkg::TR_COMPLETE;
                phase_next = PH_DONE;
            end
            else
            begin
                phase_next = PH_RASTER;
            end
        end

        // Sample to pixel: gray copies, color collects three
        if (smp_ev)
        begin
            if ((fmt_reg == nsd_pkg::FMT_PGM_ASCII) || (fmt_reg == nsd_pkg::FMT_PGM_RAW))
            begin
                pix_ev = 1'b1;
                pix_r  = smp_val;
                pix_g  = smp_val;
                pix_b  = smp_val;
            end
            else if (ch_reg == 2'd0)
            begin
                red_hold_next = smp_val;
                ch_next       = 2'd1;
            end
            else if (ch_reg == 2'd1)
            begin
                green_hold_next = smp_val;
                ch_next         = 2'd2;
            end
            else
            begin
                ch_next = 2'd0;
                pix_ev  = 1'b1;
                pix_r   = red_hold_reg;
                pix_g   = green_hold_reg;
                pix_b   = smp_val;
            end
        end

        // Single pixel and raster position
        if (pix_ev)
        begin
            cmd.prim  = nsd_pkg::PR_PIXEL;
            cmd.col   = 16'(col_reg);
            cmd.row   = 16'(row_reg);
            cmd.val_a = pix_r;
            cmd.val_b = pix_g;
            cmd.val_c = pix_b;
            col_inc   = {1'b0, col_reg} + 1'b1;
            if (col_inc >= {1'b0, width_reg})
            begin
                col_next = '0;
                row_inc  = {1'b0, row_reg} + 1'b1;
                row_next = row_inc[COORD_BITS-1:0];
                if (row_inc >= {1'b0, height_reg})
                begin
                    cmd.trail  = nsd_pkg::TR_COMPLETE;
                    phase_next = PH_DONE;
                end
            end
            else
            begin
                col_next = col_inc[COORD_BITS-1:0];
            end
        end

        // Raw bitmap byte: up to eight pixels, stops at row end
        if (p4_ev)
        begin
            p4_rem   = width_reg - col_reg;
            p4_cnt   = (p4_rem >= COORD_BITS'(8)) ? 4'd8 : p4_rem[3:0];
            cmd.prim = nsd_pkg::PR_BITS;
            cmd.col  = 16'(col_reg);
            cmd.row  = 16'(row_reg);
            cmd.bits = data_byte;
            cmd.cnt  = p4_cnt;
            col_sum  = {1'b0, col_reg} + (COORD_BITS+1)'(p4_cnt);
            if (col_sum == {1'b0, width_reg})
            begin
                col_next = '0;
                row_inc  = {1'b0, row_reg} + 1'b1;
                row_next = row_inc[COORD_BITS-1:0];
                if (row_inc >= {1'b0, height_reg})
                begin
                    cmd.trail  = nsd_pkg::TR_COMPLETE;
                    phase_next = PH_DONE;
                end
            end
            else
            begin
                col_next = col_sum[COORD_BITS-1:0];
            end
        end

        cmd.fmt = fmt_next;

        // End of file: truncation check, then back to reset
        if (end_of_file)
        begin
            if ((phase_next != PH_DONE) && (phase_next != PH_ERR))
            begin
                cmd.trail = nsd_pkg::TR_TRUNC;
            end
            phase_next      = PH_MAGIC0;
            fmt_next        = nsd_pkg::FMT_UNKNOWN;
            width_next      = '0;
            height_next     = '0;
            maxval_next     = 16'd1;
            acc_next        = '0;
            tok_next        = 1'b0;
            cmt_next        = 1'b0;
            col_next        = '0;
            row_next        = '0;
            ch_next         = '0;
            hb_next         = '0;
            half_next       = 1'b0;
            red_hold_next   = '0;
            green_hold_next = '0;
        end
    end

    assign push = in_fire && ((cmd.prim != nsd_pkg::PR_NONE) || (cmd.trail != nsd_pkg::TR_NONE));

    // Parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= PH_MAGIC0;
            fmt_reg        <= nsd_pkg::FMT_UNKNOWN;
            width_reg      <= '0;
            height_reg     <= '0;
            maxval_reg     <= 16'd1;
            acc_reg        <= '0;
            tok_reg        <= 1'b0;
            cmt_reg        <= 1'b0;
            col_reg        <= '0;
            row_reg        <= '0;
            ch_reg         <= '0;
            hb_reg         <= '0;
            half_reg       <= 1'b0;
            red_hold_reg   <= '0;
            green_hold_reg <= '0;
        end
        else if (in_fire)
        begin
            phase_reg      <= phase_next;
            fmt_reg        <= fmt_next;
            width_reg      <= width_next;
            height_reg     <= height_next;
            maxval_reg     <= maxval_next;
            acc_reg        <= acc_next;
            tok_reg        <= tok_next;
            cmt_reg        <= cmt_next;
            col_reg        <= col_next;
            row_reg        <= row_next;
            ch_reg         <= ch_next;
            hb_reg         <= hb_next;
            half_reg       <= half_next;
            red_hold_reg   <= red_hold_next;
            green_hold_reg <= green_hold_next;
        end
    end

    // A number is only open inside the text phases
    assert property (@(posedge clk) disable iff (!rst_n)
        tok_reg |-> (phase_reg == PH_WIDTH || phase_reg == PH_HEIGHT
                     || phase_reg == PH_MAXV || phase_reg == PH_RASTER))
        else $error("number open outside text phase");

    // Raster position stays inside the image
    assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_RASTER) |-> (col_reg < width_reg && row_reg < height_reg))
        else $error("raster position out of range");

endmodule

// ----- rtl/core/nsd_queue.sv -----
`timescale 1ns / 1ps

module nsd_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  nsd_pkg::cmd_t push_cmd,
    input  logic          pop,
    output nsd_pkg::cmd_t head,
    output logic          empty,
    output logic          full
);

    localparam int PB = nsd_pkg::NSD_QPTR_BITS;

    nsd_pkg::cmd_t mem [nsd_pkg::NSD_QDEPTH];
    logic [PB-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PB:0]   count_reg;

    assign empty = (count_reg == '0);
    assign full  = (count_reg == (PB+1)'(nsd_pkg::NSD_QDEPTH));
    assign head  = mem[rd_ptr_reg];

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
        else $error("write into full queue");

    assert property (@(posedge clk) disable iff (!rst_n) !(pop && empty))
        else $error("read from empty queue");

endmodule

// ----- rtl/core/nsd_back.sv -----
`timescale 1ns / 1ps

module nsd_back (
    input  logic          clk,
    input  logic          rst_n,
    input  nsd_pkg::cmd_t head,
    input  logic          empty,
    output logic          pop,
    input  logic          out_ready,
    output logic          out_valid,
    output logic [1:0]    out_kind,
    output logic          out_last,
    output logic [135:0]  out_data
);

    logic        valid_reg;
    logic [1:0]  kind_reg, kind_next;
    logic        last_reg, last_next;
    logic [2:0]  fmt_reg;
    logic [15:0] w_reg, w_next, h_reg, h_next, m_reg, m_next;
    logic [15:0] col_reg, col_next, row_reg, row_next;
    logic [15:0] r_reg, r_next, g_reg, g_next, b_reg, b_next;
    logic [2:0]  err_reg, err_next;
    logic [2:0]  idx_reg;
    logic        stage_reg;

    logic        emit, at_trail, more_bits;
    logic        bit_val;
    logic [15:0] bit_color;

    assign emit      = !empty && (!valid_reg || out_ready);
    assign at_trail  = stage_reg || (head.prim == nsd_pkg::PR_NONE);
    assign more_bits = (head.prim == nsd_pkg::PR_BITS) && ({1'b0, idx_reg} != (head.cnt - 1'b1));
    assign bit_val   = head.bits[3'd7 - idx_reg];
    assign bit_color = bit_val ? 16'd0 : nsd_pkg::SAMPLE_MAX8;

    // Build the current result word
    always_comb
    begin
        kind_next = nsd_pkg::KIND_HEADER;
        w_next    = '0;
        h_next    = '0;
        m_next    = '0;
        col_next  = '0;
        row_next  = '0;
        r_next    = '0;
        g_next    = '0;
        b_next    = '0;
        err_next  = nsd_pkg::ERR_NONE;
        last_next = at_trail || (!more_bits && (head.trail == nsd_pkg::TR_NONE));
        if (at_trail)
        begin
            case (head.trail)
                nsd_pkg::TR_COMPLETE:
                begin
                    kind_next = nsd_pkg::KIND_COMPLETE;
                end
                default:
                begin
                    kind_next = nsd_pkg::KIND_ERROR;
                    err_next  = nsd_pkg::ERR_TRUNC;
                end
            endcase
        end
        else
        begin
            case (head.prim)
                nsd_pkg::PR_HEADER:
                begin
                    kind_next = nsd_pkg::KIND_HEADER;
                    w_next    = head.val_a;
                    h_next    = head.val_b;
                    m_next    = head.val_c;
                end
                nsd_pkg::PR_PIXEL:
                begin
                    kind_next = nsd_pkg::KIND_PIXEL;
                    col_next  = head.col;
                    row_next  = head.row;
                    r_next    = head.val_a;
                    g_next    = head.val_b;
                    b_next    = head.val_c;
                end
                nsd_pkg::PR_BITS:
                begin
                    kind_next = nsd_pkg::KIND_PIXEL;
                    col_next  = head.col + 16'(idx_reg);
                    row_next  = head.row;
                    r_next    = bit_color;
                    g_next    = bit_color;
                    b_next    = bit_color;
                end
                default:
                begin
                    kind_next = nsd_pkg::KIND_ERROR;
                    err_next  = head.err;
                end
            endcase
        end
    end

    assign pop = emit && last_next;

    // Walk through the items of the head command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= '0;
            stage_reg <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                valid_reg <= 1'b1;
                if (last_next)
                begin
                    idx_reg   <= '0;
                    stage_reg <= 1'b0;
                end
                else if (!at_trail && more_bits)
                begin
                    idx_reg <= idx_reg + 1'b1;
                end
                else
                begin
                    idx_reg   <= '0;
                    stage_reg <= 1'b1;
                end
            end
            else if (out_ready)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    // Output word register
    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            kind_reg <= kind_next;
            last_reg <= last_next;
            fmt_reg  <= head.fmt;
            w_reg    <= w_next;
            h_reg    <= h_next;
            m_reg    <= m_next;
            col_reg  <= col_next;
            row_reg  <= row_next;
            r_reg    <= r_next;
            g_reg    <= g_next;
            b_reg    <= b_next;
            err_reg  <= err_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_kind  = kind_reg;
    assign out_last  = last_reg;
    assign out_data  = {2'b00, err_reg, b_reg, g_reg, r_reg, row_reg, col_reg,
                        m_reg, h_reg, w_reg, fmt_reg};

    // Bit index never passes the pixel count of the byte
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && head.prim == nsd_pkg::PR_BITS && !stage_reg) |-> ({1'b0, idx_reg} < head.cnt))
        else $error("bitmap index beyond pixel count");

endmodule

// ----- rtl/core/netpbm_stream_decoder_top.sv -----
// Path: an accepted byte's command is written into the command queue, then the emitter
// loads its result words into the output register. Throughput: one input byte per cycle
// while the queue has room; results leave at one word per cycle while m_tready is high, so
// one byte can give up to nine words (eight raw bitmap pixels plus a completion or truncation
// word). A four-entry queue between parser and emitter absorbs these; input stalls only when full.
// Reset (rst_n, async low) returns the parser to expecting the magic and empties queue.
`timescale 1ns / 1ps

module netpbm_stream_decoder_top #(
    parameter int COORD_BITS = nsd_pkg::NSD_COORD_BITS
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // data_byte[7:0]
    input  logic         s_tlast,   // end_of_file
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [135:0] m_tdata,   // format[2:0], image_width[18:3], image_height[34:19],
                                    // max_value[50:35], column[66:51], row[82:67],
                                    // red[98:83], green[114:99], blue[130:115],
                                    // error_code[133:131], zero pad
    output logic [1:0]   m_tuser,   // kind[1:0]
    output logic         m_tlast    // last
);

    nsd_pkg::cmd_t push_cmd, head;
    logic          push, pop, empty, full, in_fire;

    assign s_tready = !full;
    assign in_fire  = s_tvalid && s_tready;

    nsd_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .data_byte   (s_tdata),
        .end_of_file (s_tlast),
        .push        (push),
        .cmd         (push_cmd)
    );

    nsd_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .empty    (empty),
        .full     (full)
    );

    nsd_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .empty     (empty),
        .pop       (pop),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_kind  (m_tuser),
        .out_last  (m_tlast),
        .out_data  (m_tdata)
    );

endmodule

// ----- verif/tb_netpbm_stream_decoder_top.sv -----
`timescale 1ns / 1ps

module tb_netpbm_stream_decoder_top;

    localparam int CYCLE_LIMIT = 600000;
    localparam int MAX_WORDS   = 9;
    localparam int TARGET_BYTES = 320;
    localparam int unsigned COORD_MAX = 65535;

    logic         clk;
    logic         rst_n;
    logic         s_tvalid;
    logic         s_tready;
    logic [7:0]   s_tdata;   // data_byte[7:0]
    logic         s_tlast;   // end_of_file
    logic         m_tvalid;
    logic         m_tready;
    logic [135:0] m_tdata;   // format, width, height, maxval, column, row, red, green, blue, error
    logic [1:0]   m_tuser;   // kind[1:0]
    logic         m_tlast;   // last

    netpbm_stream_decoder_top DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    typedef enum int {
        PH_MAGIC0, PH_MAGIC1, PH_SEP, PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_RASTER, PH_DONE, PH_ERR
    } parse_phase_t;

    typedef struct {
        logic [1:0]  kind;
        logic [2:0]  fmt;
        logic [15:0] w, h, mx, col, row, r, g, b;
        logic [2:0]  err;
        logic        last;
    } pnm_word_t;

    typedef struct {
        logic [7:0] d;
        logic       e;
    } file_byte_t;

    typedef struct {
        logic [7:0] d;
        logic       e;
        bit         typed;
        logic [2:0] fmt;
        logic [2:0] err;
    } dir_row_t;

    pnm_word_t  expected_words[$];
    pnm_word_t  step_words[$];
    file_byte_t file_bytes[$];
    int         errors;
    longint     cycles;

    // Decoder model state
    parse_phase_t ph;
    logic [2:0]   ff;
    int unsigned  wr, hr, mr, acc, cc, rc, ci, hb, bh, rh, gh;
    bit           tok, cmt;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    // ---------------- decoder model ----------------
    function automatic void model_reset();
        ph = PH_MAGIC0; ff = nsd_pkg::FMT_UNKNOWN; wr = 0; hr = 0; mr = 1; acc = 0;
        tok = 0; cmt = 0; cc = 0; rc = 0; ci = 0; hb = 0; bh = 0; rh = 0; gh = 0;
    endfunction

    function automatic void put_word(logic [1:0] kind, int unsigned w, int unsigned h,
                                     int unsigned m, int unsigned col, int unsigned row,
                                     int unsigned r, int unsigned g, int unsigned b,
                                     logic [2:0] err);
        pnm_word_t x;
        if (step_words.size() >= MAX_WORDS) return;
        x.kind = kind; x.fmt = ff; x.w = w[15:0]; x.h = h[15:0]; x.mx = m[15:0];
        x.col = col[15:0]; x.row = row[15:0]; x.r = r[15:0]; x.g = g[15:0];
        x.b = b[15:0]; x.err = err; x.last = 1'b0;
        step_words.push_back(x);
    endfunction

    function automatic void raise_error(logic [2:0] code);
        put_word(nsd_pkg::KIND_ERROR, 0, 0, 0, 0, 0, 0, 0, 0, code);
        ph = PH_ERR;
    endfunction

    function automatic void emit_pixel(int unsigned r, int unsigned g, int unsigned b);
        put_word(nsd_pkg::KIND_PIXEL, 0, 0, 0, cc, rc, r, g, b, nsd_pkg::ERR_NONE);
        cc++;
        if (cc >= wr) begin
            cc = 0;
            rc++;
            if (rc >= hr) begin
                put_word(nsd_pkg::KIND_COMPLETE, 0, 0, 0, 0, 0, 0, 0, 0, nsd_pkg::ERR_NONE);
                ph = PH_DONE;
            end
        end
    endfunction

    function automatic void take_sample(int unsigned s);
        if (ff == nsd_pkg::FMT_PGM_ASCII || ff == nsd_pkg::FMT_PGM_RAW) emit_pixel(s, s, s);
        else if (ci == 0) begin rh = s; ci = 1; end
        else if (ci == 1) begin gh = s; ci = 2; end
        else begin ci = 0; emit_pixel(rh, gh, s); end
    endfunction

    function automatic void header_done();
        put_word(nsd_pkg::KIND_HEADER, wr, hr, mr, 0, 0, 0, 0, 0, nsd_pkg::ERR_NONE);
        cc = 0; rc = 0; ci = 0; bh = 0;
        if (wr == 0 || hr == 0) begin
            put_word(nsd_pkg::KIND_COMPLETE, 0, 0, 0, 0, 0, 0, 0, 0, nsd_pkg::ERR_NONE);
            ph = PH_DONE;
        end
        else ph = PH_RASTER;
    endfunction

    function automatic void end_number();
        int unsigned v;
        int unsigned lim;
        v = acc; acc = 0; tok = 0;
        case (ph)
            PH_WIDTH: begin wr = (v > COORD_MAX) ? COORD_MAX : v; ph = PH_HEIGHT; end
            PH_HEIGHT:
            begin
                hr = (v > COORD_MAX) ? COORD_MAX : v;
                if (ff == nsd_pkg::FMT_PBM_ASCII || ff == nsd_pkg::FMT_PBM_RAW) begin
                    mr = 1; header_done();
                end
                else ph = PH_MAXV;
            end
            PH_MAXV:
            begin
                if (v > 65535) raise_error(nsd_pkg::ERR_MAXVAL);
                else begin mr = v; header_done(); end
            end
            PH_RASTER:
            begin
                lim = (mr > 255) ? 65535 : 255;
                take_sample((v > lim) ? lim : v);
            end
            default: ;
        endcase
    endfunction

    function automatic void text_char(logic [7:0] c);
        if (c >= nsd_pkg::CH_ZERO && c <= nsd_pkg::CH_NINE) begin
            acc = acc * 10 + (c - nsd_pkg::CH_ZERO);
            if (acc > 65536) acc = 65536;
            tok = 1;
        end
        else if (c == nsd_pkg::CH_HASH) begin
            if (tok) end_number();
            cmt = 1;
        end
        else if (c == nsd_pkg::CH_SPACE || (c >= nsd_pkg::CH_TAB && c <= nsd_pkg::CH_CR)) begin
            if (tok) end_number();
        end
    endfunction

    function automatic void raster_char(logic [7:0] c);
        int k;
        if (ff == nsd_pkg::FMT_PBM_ASCII) begin
            if (c == nsd_pkg::CH_ONE) emit_pixel(0, 0, 0);
            else if (c == nsd_pkg::CH_ZERO) emit_pixel(255, 255, 255);
            else if (c == nsd_pkg::CH_HASH) cmt = 1;
        end
        else if (ff == nsd_pkg::FMT_PGM_ASCII || ff == nsd_pkg::FMT_PPM_ASCII) text_char(c);
        else if (ff == nsd_pkg::FMT_PBM_RAW) begin
            k = 0;
            do begin
                if (c[7-k]) emit_pixel(0, 0, 0); else emit_pixel(255, 255, 255);
                k++;
            end while (k < 8 && cc != 0 && ph == PH_RASTER);
        end
        else if (mr > 255) begin
            if (bh == 0) begin hb = c; bh = 1; end
            else begin bh = 0; take_sample((hb << 8) | c); end
        end
        else take_sample(c);
    endfunction

    // Fills step_words with the words one file byte causes
    function automatic void decode_byte(logic [7:0] c, logic eof);
        bit erred;
        step_words.delete();
        case (ph)
            PH_MAGIC0:
                if (c == nsd_pkg::CH_P) ph = PH_MAGIC1;
                else raise_error(nsd_pkg::ERR_MAGIC);
            PH_MAGIC1:
                if (c >= nsd_pkg::CH_ONE && c <= nsd_pkg::CH_SIX) begin
                    ff = 3'(c - nsd_pkg::CH_ZERO);
                    ph = PH_SEP;
                end
                else raise_error(nsd_pkg::ERR_MAGIC);
            PH_SEP:
                if (c == nsd_pkg::CH_SPACE || (c >= nsd_pkg::CH_TAB && c <= nsd_pkg::CH_CR))
                    ph = PH_WIDTH;
                else raise_error(nsd_pkg::ERR_SEP);
            PH_WIDTH, PH_HEIGHT, PH_MAXV, PH_RASTER:
            begin
                if (cmt) begin
                    if (c == nsd_pkg::CH_LF || c == nsd_pkg::CH_CR) cmt = 0;
                end
                else if (ph == PH_RASTER) raster_char(c);
                else text_char(c);
            end
            default: ;
        endcase
        erred = (ph == PH_ERR);
        if (eof) begin
            if (tok && ph >= PH_WIDTH && ph <= PH_RASTER) end_number();
            if (ph != PH_DONE && ph != PH_ERR && !erred) raise_error(nsd_pkg::ERR_TRUNC);
            model_reset();
        end
        if (step_words.size() > 0) step_words[step_words.size()-1].last = 1'b1;
    endfunction

    // ---------------- stimulus ----------------
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50) return 0;
        if (p < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic void add_byte(logic [7:0] c);
        file_byte_t x;
        x.d = c; x.e = 1'b0;
        file_bytes.push_back(x);
    endfunction

    function automatic void add_num(int unsigned v);
        string s;
        s = $sformatf("%0d", v);
        for (int i = 0; i < s.len(); i++) add_byte(s[i]);
    endfunction

    function automatic logic [7:0] pick_space();
        int p;
        p = $urandom_range(0, 5);
        case (p)
            0: return nsd_pkg::CH_TAB;
            1: return nsd_pkg::CH_LF;
            2: return nsd_pkg::CH_CR;
            3: return 8'h0B;
            4: return 8'h0C;
            default: return nsd_pkg::CH_SPACE;
        endcase
    endfunction

    // Whitespace run, now and then a comment or a stray byte
    function automatic void add_gap_text();
        int n;
        n = $urandom_range(1, 3);
        for (int i = 0; i < n; i++) add_byte(pick_space());
        if ($urandom_range(0, 7) == 0) begin
            add_byte(nsd_pkg::CH_HASH); add_byte(8'h61); add_byte(8'hFE);
            add_byte(($urandom_range(0, 1) != 0) ? nsd_pkg::CH_LF : nsd_pkg::CH_CR);
        end
        if ($urandom_range(0, 11) == 0) add_byte(8'h7A);
    endfunction

    // One file, well-formed most of the time
    function automatic void build_file();
        int unsigned fmt, w, h, mv, nsamp, nbytes, cut;
        if ($urandom_range(0, 9) == 0) begin
            nbytes = $urandom_range(1, 6);
            for (int i = 0; i < nbytes; i++) add_byte(8'($urandom_range(0, 255)));
        end
        else begin
            fmt = $urandom_range(1, 6);
            w = ($urandom_range(0, 15) == 0) ? 70000 : $urandom_range(0, 5);
            h = $urandom_range(0, 3);
            case ($urandom_range(0, 7))
                0: mv = 0;
                1: mv = 1;
                2: mv = 256;
                3: mv = 65535;
                4: mv = 70000;
                5: mv = $urandom_range(2, 65535);
                default: mv = 255;
            endcase
            add_byte(nsd_pkg::CH_P);
            add_byte(8'(nsd_pkg::CH_ZERO + fmt));
            add_byte(($urandom_range(0, 11) == 0) ? 8'h61 : pick_space());
            if ($urandom_range(0, 2) == 0) add_gap_text();
            add_num(w); add_gap_text(); add_num(h);
            if (fmt != 1 && fmt != 4) begin add_gap_text(); add_num(mv); end
            if (fmt >= 4) add_byte(pick_space()); else add_gap_text();
            nsamp = ((w > 100) ? 3 : w * h) * ((fmt == 3 || fmt == 6) ? 3 : 1);
            case (fmt)
                1:
                    for (int i = 0; i < nsamp; i++) begin
                        add_byte(($urandom_range(0, 1) != 0) ? nsd_pkg::CH_ONE
                                                              : nsd_pkg::CH_ZERO);
                        if ($urandom_range(0, 3) == 0) add_gap_text();
                    end
                2, 3:
                    for (int i = 0; i < nsamp; i++) begin
                        if ($urandom_range(0, 9) == 0) add_num(99999);
                        else add_num($urandom_range(0, (mv > 255) ? 65535 : 255));
                        add_gap_text();
                    end
                4:
                begin
                    nbytes = (w > 100) ? 2 : h * ((w + 7) / 8);
                    for (int i = 0; i < nbytes; i++) add_byte(8'($urandom_range(0, 255)));
                end
                default:
                begin
                    nbytes = nsamp * ((mv > 255) ? 2 : 1);
                    for (int i = 0; i < nbytes; i++) add_byte(8'($urandom_range(0, 255)));
                end
            endcase
            if ($urandom_range(0, 5) == 0) begin
                cut = $urandom_range(1, 4);
                while (cut > 0 && file_bytes.size() > 1) begin
                    void'(file_bytes.pop_back());
                    cut--;
                end
            end
            if ($urandom_range(0, 5) == 0) begin
                nbytes = $urandom_range(1, 3);
                for (int i = 0; i < nbytes; i++) add_byte(8'($urandom_range(0, 255)));
            end
        end
        file_bytes[file_bytes.size()-1].e = 1'b1;
    endfunction

    // Drives one byte and returns at the edge that accepts it
    task automatic send_byte(logic [7:0] d, logic e);
        int gap;
        bit ok;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        s_tlast  <= e;
        do begin
            @(negedge clk);
            ok = s_tready;
            @(posedge clk);
        end while (!ok);
    endtask

    // Directed table: a typed row checks one error word, the rest use the model
    dir_row_t dir_rows[26] = '{
        '{8'h58, 1'b1, 1'b1, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_MAGIC},
        '{nsd_pkg::CH_P,  1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{8'h37, 1'b1, 1'b1, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_MAGIC},
        '{nsd_pkg::CH_P,  1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_ONE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{8'h78, 1'b1, 1'b1, nsd_pkg::FMT_PBM_ASCII, nsd_pkg::ERR_SEP},
        '{nsd_pkg::CH_P,  1'b1, 1'b1, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_TRUNC},
        '{8'h00, 1'b1, 1'b1, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_MAGIC},
        '{nsd_pkg::CH_P,  1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{8'h34, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_SPACE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_ONE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_TAB, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_ONE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_LF, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{8'hFF, 1'b1, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_P,  1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{8'h35, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_CR, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_ONE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_SPACE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_ONE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_SPACE, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_ZERO, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{nsd_pkg::CH_LF, 1'b0, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE},
        '{8'hFF, 1'b1, 1'b0, nsd_pkg::FMT_UNKNOWN, nsd_pkg::ERR_NONE}
    };

    // Main sequence: reset, directed table, random files, drain
    initial
    begin
        pnm_word_t x;
        int sent;
        bit paused;
        errors = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tlast = 1'b0;
        model_reset();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (dir_rows[i]) begin
            send_byte(dir_rows[i].d, dir_rows[i].e);
            decode_byte(dir_rows[i].d, dir_rows[i].e);
            if (dir_rows[i].typed) begin
                x = '{nsd_pkg::KIND_ERROR, dir_rows[i].fmt, 0, 0, 0, 0, 0, 0, 0, 0,
                      dir_rows[i].err, 1'b1};
                expected_words.push_back(x);
            end
            else foreach (step_words[j]) expected_words.push_back(step_words[j]);
        end

        sent = 0;
        paused = 0;
        while (sent < TARGET_BYTES) begin
            file_bytes.delete();
            build_file();
            // hold the sender until the decoder has drained
            if (!paused && sent > TARGET_BYTES / 2) begin
                paused = 1;
                s_tvalid <= 1'b0;
                do @(posedge clk); while (expected_words.size() != 0);
            end
            foreach (file_bytes[i]) begin
                send_byte(file_bytes[i].d, file_bytes[i].e);
                decode_byte(file_bytes[i].d, file_bytes[i].e);
                foreach (step_words[j]) expected_words.push_back(step_words[j]);
                sent++;
            end
        end
        s_tvalid <= 1'b0;

        while (expected_words.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0)
            $display("netpbm_stream_decoder_top test passed");
        else
            $display("netpbm_stream_decoder_top test failed");
        $finish;
    end

    // Result side: ready bursts and random stalls
    initial
    begin
        int stall;
        m_tready = 1'b0;
        @(posedge clk iff rst_n);
        forever begin
            stall = pick_gap();
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
            if (stall > 0) begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    // Compare each accepted result word with the oldest expected one
    always @(negedge clk)
    begin
        pnm_word_t x;
        if (rst_n && m_tvalid && m_tready) begin
            if (expected_words.size() == 0) begin
                $error("unexpected result word kind=%0d", m_tuser);
                errors++;
            end
            else begin
                x = expected_words.pop_front();
                if (m_tuser !== x.kind) begin
                    $error("kind exp %0d got %0d", x.kind, m_tuser); errors++;
                end
                if (m_tdata[2:0] !== x.fmt) begin
                    $error("format exp %0d got %0d", x.fmt, m_tdata[2:0]); errors++;
                end
                if (m_tdata[18:3] !== x.w) begin
                    $error("image_width exp %0d got %0d", x.w, m_tdata[18:3]); errors++;
                end
                if (m_tdata[34:19] !== x.h) begin
                    $error("image_height exp %0d got %0d", x.h, m_tdata[34:19]); errors++;
                end
                if (m_tdata[50:35] !== x.mx) begin
                    $error("max_value exp %0d got %0d", x.mx, m_tdata[50:35]); errors++;
                end
                if (m_tdata[66:51] !== x.col) begin
                    $error("column exp %0d got %0d", x.col, m_tdata[66:51]); errors++;
                end
                if (m_tdata[82:67] !== x.row) begin
                    $error("row exp %0d got %0d", x.row, m_tdata[82:67]); errors++;
                end
                if (m_tdata[98:83] !== x.r) begin
                    $error("red exp %0d got %0d", x.r, m_tdata[98:83]); errors++;
                end
                if (m_tdata[114:99] !== x.g) begin
                    $error("green exp %0d got %0d", x.g, m_tdata[114:99]); errors++;
                end
                if (m_tdata[130:115] !== x.b) begin
                    $error("blue exp %0d got %0d", x.b, m_tdata[130:115]); errors++;
                end
                if (m_tdata[133:131] !== x.err) begin
                    $error("error_code exp %0d got %0d", x.err, m_tdata[133:131]); errors++;
                end
                if (m_tlast !== x.last) begin
                    $error("last exp %0d got %0d", x.last, m_tlast); errors++;
                end
            end
        end
    end

    // Watchdog
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("netpbm_stream_decoder_top test failed");
            $finish;
        end
    end

endmodule
